// File: sv/voxel_palette_packer_core_defines.svh
// ----------------------------------------------------------------------------
// Voxel palette packer assertion macros
// Shared concurrent assertion forms for the packer modules.
// ----------------------------------------------------------------------------
`ifndef VOXEL_PALETTE_PACKER_CORE_DEFINES_SVH
`define VOXEL_PALETTE_PACKER_CORE_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define VPP_ASSERT_NOW(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define VPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define VPP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/vpp_pkg.sv
// ----------------------------------------------------------------------------
// Voxel palette packer package
// Beat types, result codes, chain control and controller states.
// ----------------------------------------------------------------------------
package vpp_pkg;

  localparam int VOXEL_W   = 64;
  localparam int INDEX_W   = 6;
  localparam int OUTCOME_W = 2;
  localparam int TOTAL_W   = 7;
  localparam int LIMIT_W   = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_MATCH  = 2'd0,
    OUTCOME_APPEND = 2'd1,
    OUTCOME_FAIL   = 2'd2
  } vpp_outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } vpp_state_t;

  typedef struct packed {
    logic [VOXEL_W-1:0] voxel_value;
    logic               chunk_last;
  } vpp_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] palette_index;
    vpp_outcome_t       outcome;
    logic [TOTAL_W-1:0] entry_total;
    logic               result_last;
  } vpp_out_t;

  typedef struct packed {
    logic append;
    logic kill;
  } vpp_chain_ctl_t;

endpackage

// File: sv/vpp_cell.sv
// ----------------------------------------------------------------------------
// Voxel palette packer cell
// Holds one palette entry and one stage of the walking token.
// ----------------------------------------------------------------------------
module vpp_cell #(
  parameter int VOXEL_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  vpp_pkg::vpp_chain_ctl_t ctl,
  input  logic [VOXEL_BITS-1:0]   value,
  input  logic                    active_in,
  output logic                    active,
  output logic                    match
);

  logic [VOXEL_BITS-1:0] entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.kill) begin
      active <= 1'b0;
    end else begin
      active <= active_in;
    end
  end

  always_ff @(posedge clk) begin
    if (active && ctl.append) begin
      entry <= value;
    end
  end

  assign match = active && (entry == value);

endmodule

// File: sv/vpp_ctrl.sv
// ----------------------------------------------------------------------------
// Voxel palette packer controller
// Handshakes, palette count, failure flag, token walk and result register.
// ----------------------------------------------------------------------------
`include "voxel_palette_packer_core_defines.svh"

module vpp_ctrl #(
  parameter int PALETTE_DEPTH = 64,
  parameter int VOXEL_BITS    = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [vpp_pkg::LIMIT_W-1:0]         cfg_wr_data,
  input  logic                                voxel_valid,
  output logic                                voxel_ready,
  input  vpp_pkg::vpp_in_t                    voxel,
  output logic                                result_valid,
  input  logic                                result_ready,
  output vpp_pkg::vpp_out_t                   result,
  input  logic [PALETTE_DEPTH-1:0]            match,
  output logic                                start,
  output vpp_pkg::vpp_chain_ctl_t             ctl,
  output logic [VOXEL_BITS-1:0]               value
);

  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > vpp_pkg::LIMIT_W) ? CNT_W : vpp_pkg::LIMIT_W;
  localparam int IXW_W = (CNT_W > vpp_pkg::INDEX_W) ? CNT_W : vpp_pkg::INDEX_W;
  localparam int TOT_W = (CNT_W > vpp_pkg::TOTAL_W) ? CNT_W : vpp_pkg::TOTAL_W;

  vpp_pkg::vpp_state_t          state, state_next;
  logic [CNT_W-1:0]             pos, pos_next;
  logic [CNT_W-1:0]             count, count_next;
  logic                         chunk_failed, chunk_failed_next;
  logic [vpp_pkg::LIMIT_W-1:0]  limit;
  logic                         last;
  vpp_pkg::vpp_out_t            res, res_next;
  logic                         result_valid_next;

  logic             accept;
  logic             at_end;
  logic             hit;
  logic             room;
  logic             decide;
  logic             fail_new;
  logic [CNT_W-1:0] count_base;
  logic [IXW_W-1:0] pos_wide;
  logic [TOT_W-1:0] total_wide;
  logic             out_free;

  assign accept   = voxel_valid && voxel_ready;
  assign at_end   = (pos == count);
  assign hit      = (|match) && !at_end;
  assign room     = (count < CNT_W'(PALETTE_DEPTH)) && (CMP_W'(count) < CMP_W'(limit));
  assign decide   = (state == vpp_pkg::ST_WALK) && (chunk_failed || hit || at_end);
  assign fail_new = !chunk_failed && !hit && at_end && !room;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      vpp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = vpp_pkg::ST_WALK;
        end
      end
      vpp_pkg::ST_WALK: begin
        if (decide) begin
          state_next = vpp_pkg::ST_DONE;
        end
      end
      vpp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = vpp_pkg::ST_IDLE;
        end
      end
      default: state_next = vpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    voxel_ready = 1'b0;
    start       = 1'b0;
    ctl.append  = 1'b0;
    ctl.kill    = 1'b0;
    unique case (state)
      vpp_pkg::ST_IDLE: begin
        voxel_ready = 1'b1;
        start       = voxel_valid && !chunk_failed;
      end
      vpp_pkg::ST_WALK: begin
        ctl.kill   = decide;
        ctl.append = !chunk_failed && !hit && at_end && room;
      end
      vpp_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pos_next          = pos;
    count_next        = count;
    chunk_failed_next = chunk_failed;
    res_next          = res;
    count_base        = ctl.append ? (count + CNT_W'(1)) : count;
    pos_wide          = IXW_W'(pos);
    total_wide        = TOT_W'(count_base);
    result_valid_next = result_valid && !result_ready;
    if (accept) begin
      pos_next = '0;
    end else if ((state == vpp_pkg::ST_WALK) && !decide) begin
      pos_next = pos + CNT_W'(1);
    end
    if (decide) begin
      res_next.result_last = last;
      res_next.entry_total = total_wide[vpp_pkg::TOTAL_W-1:0];
      if (chunk_failed || fail_new) begin
        res_next.outcome       = vpp_pkg::OUTCOME_FAIL;
        res_next.palette_index = '0;
      end else begin
        res_next.outcome       = hit ? vpp_pkg::OUTCOME_MATCH : vpp_pkg::OUTCOME_APPEND;
        res_next.palette_index = pos_wide[vpp_pkg::INDEX_W-1:0];
      end
      if (last) begin
        count_next        = '0;
        chunk_failed_next = 1'b0;
      end else begin
        count_next        = count_base;
        chunk_failed_next = chunk_failed || fail_new;
      end
    end
    if ((state == vpp_pkg::ST_DONE) && out_free) begin
      result_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vpp_pkg::ST_IDLE;
      pos          <= '0;
      count        <= '0;
      chunk_failed <= 1'b0;
      limit        <= vpp_pkg::LIMIT_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pos          <= pos_next;
      count        <= count_next;
      chunk_failed <= chunk_failed_next;
      result_valid <= result_valid_next;
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= voxel.voxel_value[VOXEL_BITS-1:0];
      last  <= voxel.chunk_last;
    end
    res <= res_next;
    if ((state == vpp_pkg::ST_DONE) && out_free) begin
      result <= res;
    end
  end

  `VPP_ASSERT_SAME(a_match_single, clk, rst, !at_end, $onehot0(match), "more than one cell matched")
  `VPP_ASSERT_NOW(a_count_bound, clk, rst, count <= CNT_W'(PALETTE_DEPTH), "palette count above depth")
  `VPP_ASSERT_SAME(a_append_slot, clk, rst, ctl.append, !chunk_failed && at_end && room, "append outside free slot")
  `VPP_ASSERT_NEXT(a_failed_skips, clk, rst, (state == vpp_pkg::ST_WALK) && chunk_failed, state == vpp_pkg::ST_DONE, "failed chunk walked the chain")
  `VPP_ASSERT_NEXT(a_accept_walks, clk, rst, accept, (state == vpp_pkg::ST_WALK) && (pos == '0), "beat taken without starting a walk")

endmodule

// File: sv/voxel_palette_packer_core.sv
// ----------------------------------------------------------------------------
// Voxel palette packer core
// Palette encoding of a voxel stream through a chain of compare cells.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------
//  voxel    | voxel_valid / voxel_ready   | vpp_pkg::vpp_in_t
//  result   | result_valid / result_ready | vpp_pkg::vpp_out_t
//  config   | cfg_wr_en                   | cfg_wr_data (limit)
//
//  One beat at a time: a token walks the cell chain one cell per cycle; the walk
//  ends on a failed chunk, on a hit, or on a miss after all count entries, and
//  the beat then passes through the done state to the result register.
//  The result register frees the input side: a new voxel is taken while the
//  previous result still waits on result_ready; a stalled result holds the
//  next beat in its final step. Reset clears count and failure flag and sets
//  the limit to 64.
//
module voxel_palette_packer_core #(
  parameter int PALETTE_DEPTH = 64,
  parameter int VOXEL_BITS    = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [vpp_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                        voxel_valid,
  output logic                        voxel_ready,
  input  vpp_pkg::vpp_in_t            voxel,
  output logic                        result_valid,
  input  logic                        result_ready,
  output vpp_pkg::vpp_out_t           result
);

  logic [PALETTE_DEPTH-1:0] match;
  logic [PALETTE_DEPTH-1:0] active;
  logic                     start;
  vpp_pkg::vpp_chain_ctl_t  ctl;
  logic [VOXEL_BITS-1:0]    value;

  vpp_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .VOXEL_BITS    (VOXEL_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .voxel_valid  (voxel_valid),
    .voxel_ready  (voxel_ready),
    .voxel        (voxel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .match        (match),
    .start        (start),
    .ctl          (ctl),
    .value        (value)
  );

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    logic active_in;
    if (i == 0) begin : g_head
      assign active_in = start;
    end else begin : g_link
      assign active_in = active[i-1];
    end
    vpp_cell #(
      .VOXEL_BITS (VOXEL_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .value     (value),
      .active_in (active_in),
      .active    (active[i]),
      .match     (match[i])
    );
  end

endmodule
